FILE: sv/sdrrip_pkg.sv
// Shared types and codes for the set-dueling RRIP replacement block.
`timescale 1ns / 1ps
`default_nettype none

package sdrrip_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_VICTIM = 2'd0,
    OP_FILL   = 2'd1,
    OP_ACCESS = 2'd2
  } sdrrip_op_e;

  // Set roles in the insertion duel.
  typedef enum logic [1:0] {
    ROLE_LRU      = 2'd0,
    ROLE_SRRIP    = 2'd1,
    ROLE_FOLLOWER = 2'd2
  } sdrrip_role_e;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_MODIFY = 2'd2
  } sdrrip_state_e;

  // One request word.
  typedef struct packed {
    logic [1:0]  operation;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic        hit;
    logic [15:0] valid_mask;
    logic [1:0]  duel_role;
  } sdrrip_req_t;

  // One result word.
  typedef struct packed {
    logic [3:0] victim_way;
    logic       took_invalid;
    logic       followers_srrip;
  } sdrrip_rsp_t;

endpackage

`default_nettype wire

FILE: sv/sdrrip_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sdrrip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/sdrrip_update.sv
// Row modify unit: victim choice, aging, insertion, promotion and duel counter update.
`timescale 1ns / 1ps
`default_nettype none

module sdrrip_update #(
  parameter int SETS      = 2048,
  parameter int WAYS      = 16,
  parameter int RRPV_BITS = 2,
  parameter int PSEL_BITS = 10
) (
  input  wire sdrrip_pkg::sdrrip_req_t         req_i,
  input  wire logic [WAYS*RRPV_BITS-1:0]       row_i,
  input  wire logic [PSEL_BITS-1:0]            psel_i,
  output logic      [WAYS*RRPV_BITS-1:0]       row_o,
  output logic                                 row_we_o,
  output logic      [PSEL_BITS-1:0]            psel_o,
  output sdrrip_pkg::sdrrip_rsp_t              rsp_o
);
  import sdrrip_pkg::*;

  localparam int RW     = RRPV_BITS;
  localparam int WW     = $clog2(WAYS);
  localparam int LEVELS = 1 << RW;
  localparam logic [RW-1:0]        RMAX  = {RW{1'b1}};
  localparam logic [RW-1:0]        RNEAR = RMAX - RW'(1);
  localparam logic [PSEL_BITS-1:0] PTOP  = {PSEL_BITS{1'b1}};
  localparam logic [PSEL_BITS-1:0] PMID  = PSEL_BITS'(1) << (PSEL_BITS - 1);

  logic [RW-1:0]     fld [WAYS];
  logic [31:0]       mask_ext;
  logic [WAYS-1:0]   valid_ext;
  logic              set_ok;
  logic              way_ok;
  logic              inv_found;
  logic [WW-1:0]     inv_way;
  logic [LEVELS-1:0] has_val;
  logic [RW-1:0]     top;
  logic [RW-1:0]     add;
  logic [WW-1:0]     age_way;
  logic [WW-1:0]     wsel;
  logic [WAYS*RW-1:0] aged_row;
  logic [WAYS*RW-1:0] ins_row;
  logic [RW-1:0]     ins_val;

  // Range checks; ways above the mask width count as valid.
  assign set_ok    = 32'(req_i.set_index) < SETS;
  assign way_ok    = 32'(req_i.way) < WAYS;
  assign mask_ext  = {16'hFFFF, req_i.valid_mask};
  assign valid_ext = mask_ext[WAYS-1:0];
  assign wsel      = WW'(req_i.way);

  // Split the row into its per-way values.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      fld[w] = row_i[w*RW +: RW];
    end
  end

  // Lowest invalid way.
  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid_ext[w]) begin
        inv_found = 1'b1;
        inv_way   = WW'(w);
      end
    end
  end

  // Highest value present in the row, then the lowest way holding it.
  always_comb begin
    has_val = '0;
    for (int v = 0; v < LEVELS; v++) begin
      for (int w = 0; w < WAYS; w++) begin
        if (fld[w] == RW'(v)) begin
          has_val[v] = 1'b1;
        end
      end
    end
    top = '0;
    for (int v = 0; v < LEVELS; v++) begin
      if (has_val[v]) begin
        top = RW'(v);
      end
    end
    age_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (fld[w] == top) begin
        age_way = WW'(w);
      end
    end
  end

  // Aging raises every line by the same amount so the oldest reaches the maximum.
  assign add = RMAX - top;
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      aged_row[w*RW +: RW] = fld[w] + add;
    end
  end

  // Single-way insertion value and row.
  always_comb begin
    ins_row = row_i;
    ins_row[wsel*RW +: RW] = ins_val;
  end

  // Per-operation result, write-back and duel counter.
  always_comb begin
    row_o                = ins_row;
    row_we_o             = 1'b0;
    psel_o               = psel_i;
    ins_val              = '0;
    rsp_o.victim_way     = '0;
    rsp_o.took_invalid   = 1'b0;
    case (sdrrip_op_e'(req_i.operation))
      OP_VICTIM: begin
        row_o = aged_row;
        if (inv_found) begin
          rsp_o.victim_way   = 4'(inv_way);
          rsp_o.took_invalid = 1'b1;
        end else if (set_ok) begin
          rsp_o.victim_way = 4'(age_way);
          row_we_o         = 1'b1;
        end
      end
      OP_FILL: begin
        row_we_o = set_ok && way_ok;
        case (sdrrip_role_e'(req_i.duel_role))
          ROLE_LRU: begin
            ins_val = '0;
            if (row_we_o && psel_i != PTOP) begin
              psel_o = psel_i + PSEL_BITS'(1);
            end
          end
          ROLE_SRRIP: begin
            ins_val = RNEAR;
            if (row_we_o && psel_i != '0) begin
              psel_o = psel_i - PSEL_BITS'(1);
            end
          end
          default: begin
            ins_val = (psel_i > PMID) ? RNEAR : '0;
          end
        endcase
      end
      OP_ACCESS: begin
        ins_val  = '0;
        row_we_o = req_i.hit && set_ok && way_ok;
      end
      default: begin
        row_we_o = 1'b0;
      end
    endcase
    rsp_o.followers_srrip = psel_o > PMID;
  end

endmodule

`default_nettype wire

FILE: sv/set_dueling_rrip_replacement.sv
// Top level of the set-dueling RRIP replacement block: control, state memory and duel counter.
`timescale 1ns / 1ps
`default_nettype none

// Set-dueling RRIP replacement policy. The re-reference values of one set are
// held as one row of a synchronous RAM with SETS rows. After reset the block
// runs a clearing pass that writes every row to the maximum value, one row per
// cycle, and busy stays high through that pass before the first word is taken.
// After that each accepted word has its row read from the RAM and is then
// modified in the modify state, during which busy is high; the row is written
// back when the operation calls for it. The result appears on rsp_o in the
// cycle after the modify state, marked by rsp_valid_o for exactly one cycle; the
// receiver cannot stall it, and a new word may be started in that same cycle.
module set_dueling_rrip_replacement #(
  parameter int SETS      = 2048,
  parameter int WAYS      = 16,
  parameter int RRPV_BITS = 2,
  parameter int PSEL_BITS = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire sdrrip_pkg::sdrrip_req_t req_i,
  output logic                         rsp_valid_o,
  output sdrrip_pkg::sdrrip_rsp_t      rsp_o
);
  import sdrrip_pkg::*;

  localparam int AW   = $clog2(SETS);
  localparam int ROWW = WAYS * RRPV_BITS;
  localparam logic [ROWW-1:0]      ROW_RESET = {ROWW{1'b1}};
  localparam logic [AW-1:0]        LAST_ROW  = AW'(SETS - 1);
  localparam logic [PSEL_BITS-1:0] PMID      = PSEL_BITS'(1) << (PSEL_BITS - 1);

  sdrrip_state_e state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [PSEL_BITS-1:0] psel_q, psel_d;
  logic                 rsp_valid_q, rsp_valid_d;
  sdrrip_req_t          req_q;
  sdrrip_rsp_t          rsp_q;

  logic            accept;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ROWW-1:0] ram_wdata;
  logic [ROWW-1:0] ram_rdata;
  logic [ROWW-1:0] upd_row;
  logic            upd_we;
  logic [PSEL_BITS-1:0] upd_psel;
  sdrrip_rsp_t     upd_rsp;

  assign accept = start && !busy;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ROW) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control outputs and RAM write port selection.
  always_comb begin
    busy        = 1'b1;
    clr_d       = clr_q;
    psel_d      = psel_q;
    rsp_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(req_q.set_index);
    ram_wdata   = upd_row;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = ROW_RESET;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_MODIFY: begin
        ram_we      = upd_we;
        psel_d      = upd_psel;
        rsp_valid_d = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      psel_q      <= PMID;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      psel_q      <= psel_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Request and result words.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == ST_MODIFY) begin
      rsp_q <= upd_rsp;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // State memory: one row of re-reference values per set.
  sdrrip_ram #(
    .WIDTH(ROWW),
    .DEPTH(SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(AW'(req_i.set_index)),
    .rdata_o(ram_rdata)
  );

  // Row modify unit.
  sdrrip_update #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .RRPV_BITS(RRPV_BITS),
    .PSEL_BITS(PSEL_BITS)
  ) u_update (
    .req_i   (req_q),
    .row_i   (ram_rdata),
    .psel_i  (psel_q),
    .row_o   (upd_row),
    .row_we_o(upd_we),
    .psel_o  (upd_psel),
    .rsp_o   (upd_rsp)
  );

  // The result strobe is never held high: each rise is followed by a drop.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid_o |=> !rsp_valid_o)
    else $error("result strobe held for two cycles");

  // An accepted word is modified in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> state_q == ST_MODIFY)
    else $error("accepted word did not reach the modify cycle");

  // Every modify cycle yields exactly one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY) |=> rsp_valid_o)
    else $error("modify cycle produced no result");

  // The duel counter moves only in a modify cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MODIFY) |=> $stable(psel_q))
    else $error("duel counter changed outside a modify cycle");

  // No result while the clearing pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !rsp_valid_o && busy)
    else $error("result or idle seen during clearing pass");

endmodule

`default_nettype wire
